// ===== rtl/pps_pkg.sv =====
// shared types and constants for the priority scheduler
`default_nettype none
package pps_pkg;
  localparam int unsigned QueueDepthDef = 64;
  localparam int unsigned NumLevelsDef  = 4;
  localparam logic [6:0]  QuantumTenths = 7'd10;
  localparam logic        ActArrive     = 1'b0;
  localparam logic        ActTick       = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] task_id;
    logic [1:0] level;
    logic [6:0] run_tenths;
  } cmd_t;
endpackage
`default_nettype wire

// ===== rtl/pps_ram.sv =====
// generic single-port-write, registered-read ram
`default_nettype none
module pps_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/pps_front.sv =====
// command front end: accepts items into a two-entry queue
`default_nettype none
module pps_front import pps_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  input  wire cmd_t in_cmd,
  output logic      full,
  output logic      q_valid,
  output cmd_t      q_cmd,
  input  wire logic q_pop
);
  cmd_t       buf_r [2];
  logic       rd_r, rd_nxt, wr_r, wr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  assign push    = in_valid && !full;
  assign full    = cnt_r == 2'd2;
  assign q_valid = cnt_r != 2'd0;
  assign q_cmd   = buf_r[rd_r];

  always_comb begin
    rd_nxt  = rd_r ^ q_pop;
    wr_nxt  = wr_r ^ push;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      buf_r[wr_r] <= in_cmd;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/pps_back.sv =====
// scheduler back end: ready queues, running task and result formation
`default_nettype none
module pps_back import pps_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef,
  parameter int unsigned NumLevels  = NumLevelsDef
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_valid,
  input  wire cmd_t q_cmd,
  output logic      q_pop,
  output logic       out_valid,
  output logic       out_queue_full,
  output logic       out_running_valid,
  output logic [7:0] out_running_id,
  output logic       out_first_start,
  output logic       out_preempt_valid,
  output logic [7:0] out_preempt_id,
  output logic       out_completed,
  output logic       out_idle,
  output logic [7:0] out_quantum_count
);
  localparam int unsigned PW = $clog2(QueueDepth);
  localparam int unsigned LW = $clog2(NumLevels);
  localparam int unsigned AW = PW + LW;
  localparam int unsigned CW = $clog2(QueueDepth + 1);

  typedef enum logic [1:0] {
    ST_DECIDE = 2'b01,
    ST_POP    = 2'b10
  } state_t;

  state_t        st_r, st_nxt;
  logic [PW-1:0] head_r [NumLevels];
  logic [PW-1:0] tail_r [NumLevels];
  logic [CW-1:0] cnt_r  [NumLevels];
  logic          cur_v_r;
  logic [7:0]    cur_id_r;
  logic [LW-1:0] cur_lvl_r;
  logic [6:0]    cur_rem_r;
  logic [7:0]    tick_r;
  logic          pre_r;
  logic [7:0]    pre_id_r;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [15:0]   wdata, rdata;

  pps_ram #(.Width(16), .Depth(1 << AW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic [LW-1:0] arr_lvl;
  logic          higher, any_ne, do_pre, need_pop;
  logic [LW-1:0] sel_lvl;
  logic [LW-1:0] pop_lvl_r;
  logic [6:0]    run_rem;
  logic [7:0]    run_id;
  logic          run_v;

  always_comb begin
    if ({{(8-2){1'b0}}, q_cmd.level} >= 8'(NumLevels)) begin
      arr_lvl = LW'(NumLevels - 1);
    end else begin
      arr_lvl = LW'(q_cmd.level);
    end
    higher = 1'b0;
    any_ne = 1'b0;
    sel_lvl = '0;
    for (int i = NumLevels - 1; i >= 0; i--) begin
      if (cnt_r[i] != '0) begin
        any_ne  = 1'b1;
        sel_lvl = LW'(i);
        if (LW'(i) < cur_lvl_r) begin
          higher = 1'b1;
        end
      end
    end
    do_pre = cur_v_r && higher && (cnt_r[cur_lvl_r] != CW'(QueueDepth));
  end

  // decide cycle: arrival completes; tick completes or pops, preempting if due
  always_comb begin
    st_nxt = st_r;
    q_pop  = 1'b0;
    we     = 1'b0;
    waddr  = '0;
    wdata  = '0;
    raddr  = {sel_lvl, head_r[sel_lvl]};
    need_pop = 1'b0;
    case (st_r)
      ST_DECIDE: begin
        if (q_valid) begin
          if (q_cmd.action == ActArrive) begin
            q_pop = 1'b1;
            if (cnt_r[arr_lvl] != CW'(QueueDepth)) begin
              we    = 1'b1;
              waddr = {arr_lvl, tail_r[arr_lvl]};
              wdata = {1'b0, q_cmd.run_tenths, q_cmd.task_id};
            end
          end else begin
            need_pop = (!cur_v_r || do_pre) && any_ne;
            if (do_pre) begin
              we    = 1'b1;
              waddr = {cur_lvl_r, tail_r[cur_lvl_r]};
              wdata = {1'b1, cur_rem_r, cur_id_r};
            end
            if (need_pop) begin
              st_nxt = ST_POP;
            end else begin
              q_pop = 1'b1;
            end
          end
        end
      end
      ST_POP: begin
        q_pop  = 1'b1;
        st_nxt = ST_DECIDE;
      end
      default: st_nxt = ST_DECIDE;
    endcase
  end

  always_comb begin
    if (st_r == ST_POP) begin
      run_v   = 1'b1;
      run_id  = rdata[7:0];
      run_rem = rdata[14:8];
    end else begin
      run_v   = cur_v_r && !do_pre;
      run_id  = cur_id_r;
      run_rem = cur_rem_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_DECIDE;
      cur_v_r   <= 1'b0;
      cur_id_r  <= '0;
      cur_lvl_r <= '0;
      cur_rem_r <= '0;
      tick_r    <= '0;
      out_valid <= 1'b0;
      pre_r     <= 1'b0;
      pre_id_r  <= '0;
      pop_lvl_r <= '0;
      for (int i = 0; i < NumLevels; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else begin
      st_r      <= st_nxt;
      out_valid <= 1'b0;
      // queue pointer updates, wrapping at the queue depth
      if (we && st_r == ST_DECIDE) begin
        tail_r[waddr[AW-1:PW]] <= (tail_r[waddr[AW-1:PW]] == PW'(QueueDepth - 1))
                                  ? '0 : tail_r[waddr[AW-1:PW]] + PW'(1);
      end
      for (int i = 0; i < NumLevels; i++) begin
        cnt_r[i] <= cnt_r[i]
          + CW'(we && waddr[AW-1:PW] == LW'(i))
          - CW'(need_pop && sel_lvl == LW'(i));
        if (need_pop && sel_lvl == LW'(i)) begin
          head_r[i] <= (head_r[i] == PW'(QueueDepth - 1)) ? '0 : head_r[i] + PW'(1);
        end
      end
      if (st_r == ST_DECIDE && q_valid) begin
        pre_r     <= do_pre && q_cmd.action == ActTick;
        pre_id_r  <= cur_id_r;
        pop_lvl_r <= sel_lvl;
      end
      if (st_r == ST_DECIDE && q_valid && q_cmd.action == ActArrive) begin
        out_valid         <= 1'b1;
        out_queue_full    <= cnt_r[arr_lvl] == CW'(QueueDepth);
        out_running_valid <= 1'b0;
        out_running_id    <= '0;
        out_first_start   <= 1'b0;
        out_preempt_valid <= 1'b0;
        out_preempt_id    <= '0;
        out_completed     <= 1'b0;
        out_idle          <= 1'b0;
        out_quantum_count <= tick_r;
      end else if ((st_r == ST_DECIDE && q_valid && !need_pop) || st_r == ST_POP) begin
        out_valid         <= 1'b1;
        out_queue_full    <= 1'b0;
        out_running_valid <= run_v;
        out_running_id    <= run_v ? run_id : 8'd0;
        out_first_start   <= (st_r == ST_POP) && !rdata[15];
        out_preempt_valid <= (st_r == ST_POP) ? pre_r : 1'b0;
        out_preempt_id    <= (st_r == ST_POP && pre_r) ? pre_id_r : 8'd0;
        out_completed     <= run_v && run_rem <= QuantumTenths;
        out_idle          <= !run_v;
        out_quantum_count <= tick_r;
        tick_r            <= tick_r + 8'd1;
        cur_v_r           <= run_v && run_rem > QuantumTenths;
        cur_id_r          <= run_id;
        cur_rem_r         <= (run_v && run_rem > QuantumTenths) ? run_rem - QuantumTenths
                                                               : 7'd0;
        if (st_r == ST_POP) begin
          cur_lvl_r <= pop_lvl_r;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/preemptive_priority_scheduler_top.sv =====
// top level of the preemptive highest-priority-first scheduler
// usage
// - input channel: drive in_action/in_task_id/in_level/in_run_tenths with start;
//   a transfer happens at a clock edge where start is high and busy is low
// - action 0 appends a task to its level's fifo, action 1 runs one quantum tick
// - levels above the top level number saturate to the lowest priority level
// - result channel: out_valid marks each result for exactly one cycle; the
//   receiver cannot stall, so every result is a transfer when shown
// - one result per item, in item order
// back-end flow
// - an arrival is handled in the decide state alone; a tick that dispatches a
//   queued task also needs the pop state, for the registered queue memory read
// - a two-entry command queue decouples accepting from execution; busy is
//   raised only while that queue is full
// reset
// - rst_n is synchronous, active low; queues empty, no task running, tick 0
// - the queue memory is not cleared and needs no clearing pass
`default_nettype none
module preemptive_priority_scheduler_top import pps_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef,
  parameter int unsigned NumLevels  = NumLevelsDef
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic       in_action,
  input  wire logic [7:0] in_task_id,
  input  wire logic [1:0] in_level,
  input  wire logic [6:0] in_run_tenths,
  output logic            out_valid,
  output logic            out_queue_full,
  output logic            out_running_valid,
  output logic [7:0]      out_running_id,
  output logic            out_first_start,
  output logic            out_preempt_valid,
  output logic [7:0]      out_preempt_id,
  output logic            out_completed,
  output logic            out_idle,
  output logic [7:0]      out_quantum_count
);
  cmd_t in_cmd, q_cmd;
  logic q_valid, q_pop;

  assign in_cmd = '{action: in_action, task_id: in_task_id, level: in_level,
                    run_tenths: in_run_tenths};

  // front end: command capture
  pps_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(start), .in_cmd(in_cmd), .full(busy),
    .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop)
  );

  // back end: queues and running task
  pps_back #(.QueueDepth(QueueDepth), .NumLevels(NumLevels)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop),
    .out_valid(out_valid), .out_queue_full(out_queue_full),
    .out_running_valid(out_running_valid), .out_running_id(out_running_id),
    .out_first_start(out_first_start), .out_preempt_valid(out_preempt_valid),
    .out_preempt_id(out_preempt_id), .out_completed(out_completed),
    .out_idle(out_idle), .out_quantum_count(out_quantum_count)
  );
endmodule
`default_nettype wire
